// File: rtl/core/yuvc_pkg.sv
// ----------------------------------------------------------------------------
// yuvc_pkg - shared types and constants of the yuv to bgra converter
// fixed-point coefficients, sizes, register indexes and the queue item type
// ----------------------------------------------------------------------------
package yuvc_pkg;

  // frame limits
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  // config field width and register index width
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;

  // counter and line buffer sizing
  localparam int COUNT_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int IDX_W      = $clog2(LINE_DEPTH);

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // arithmetic: 16.16 coefficients, products and sums fit in 28 signed bits
  localparam int PROD_W = 28;
  localparam logic signed [PROD_W-1:0] K_LUMA    = 28'sd76283;
  localparam logic signed [PROD_W-1:0] K_RED_V   = 28'sd132251;
  localparam logic signed [PROD_W-1:0] K_GREEN_U = 28'sd53281;
  localparam logic signed [PROD_W-1:0] K_GREEN_V = 28'sd25624;
  localparam logic signed [PROD_W-1:0] K_BLUE_U  = 28'sd104595;
  localparam logic signed [PROD_W-1:0] ROUND_BIAS = 28'sd32768;
  localparam logic [7:0] LUMA_OFFSET   = 8'd16;
  localparam logic [7:0] CHROMA_OFFSET = 8'd128;
  localparam logic [7:0] ALPHA_OPAQUE  = 8'hff;

  localparam int SUM_W = 32;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_CHROMA_SUB   = 2'd2,
    CFG_ALPHA_PRES   = 2'd3
  } cfg_idx_t;

  // where a pixel's chroma pair comes from
  typedef enum logic [1:0] {
    SRC_DIRECT = 2'd0,
    SRC_FETCH  = 2'd1,
    SRC_LINE   = 2'd2,
    SRC_HELD   = 2'd3
  } chroma_src_t;

  // classified request handed from front to back
  typedef struct packed {
    logic [7:0]  luma;
    logic [15:0] pair;   // first chroma in low byte, second in high byte
    logic [7:0]  alpha;
    logic        last;
  } item_t;

  // 0 reads as 1, above the limit clips to the limit
  function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] v,
                                                input logic [CFG_W-1:0] lim);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > lim) begin
      r = lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // round at bit 15, shift by 16, clamp to 0..255
  function automatic logic [7:0] to_channel(input logic signed [PROD_W-1:0] acc);
    logic signed [PROD_W-1:0] t;
    logic [7:0] r;
    t = acc + ROUND_BIAS;
    if (t[PROD_W-1]) begin
      r = 8'd0;
    end else if (t[PROD_W-2:24] != '0) begin
      r = 8'hff;
    end else begin
      r = t[23:16];
    end
    return r;
  endfunction

endpackage

// File: rtl/core/yuvc_front.sv
// ----------------------------------------------------------------------------
// yuvc_front - pixel intake and chroma classification
// config registers, raster counters, chroma line buffer and held pair
// ----------------------------------------------------------------------------
module yuvc_front
  import yuvc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // config write channel
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // pixel input
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           in_luma,
  input  logic [7:0]           in_chroma_u,
  input  logic [7:0]           in_chroma_v,
  input  logic [7:0]           in_alpha_in,
  // toward the queue
  output logic                 q_push,
  output item_t                q_item,
  input  logic                 q_full
);

  localparam logic [CFG_W-1:0] W_LIM = CFG_W'(MAX_WIDTH);
  localparam logic [CFG_W-1:0] H_LIM = CFG_W'(MAX_HEIGHT);

  // config
  logic [CFG_W-1:0]   width_r, height_r;
  logic               sub_r, alpha_pres_r;

  // raster position
  logic [COUNT_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;

  // staged request
  logic               f_valid_r, f_valid_nxt;
  logic [7:0]         f_luma_r, f_cu_r, f_cv_r, f_alpha_r;
  logic               f_last_r;
  chroma_src_t        f_src_r;

  // chroma storage
  logic [15:0]        line_mem [LINE_DEPTH];
  logic [15:0]        rdata_r;
  logic [15:0]        held_r;

  logic               accept, f_move;
  logic               last_col, last_row, fetch_row;
  chroma_src_t        src;
  logic [IDX_W-1:0]   idx;
  logic [15:0]        pair;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r      <= CFG_W'(16);
      height_r     <= CFG_W'(16);
      sub_r        <= 1'b0;
      alpha_pres_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FRAME_WIDTH:  width_r      <= eff_size(cfg_data, W_LIM);
        CFG_FRAME_HEIGHT: height_r     <= eff_size(cfg_data, H_LIM);
        CFG_CHROMA_SUB:   sub_r        <= cfg_data[0];
        CFG_ALPHA_PRES:   alpha_pres_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign f_move = f_valid_r && !q_full;
  assign full   = f_valid_r && q_full;
  assign accept = push && !full;

  assign last_col  = ({1'b0, col_r} + 1'b1) >= width_r;
  assign last_row  = ({1'b0, row_r} + 1'b1) >= height_r;
  assign fetch_row = !row_r[0] &&
                     ((row_r == '0) || ({1'b0, row_r[ROW_W-1:1]} < height_r[CFG_W-1:1]));
  assign idx       = col_r[COUNT_W-1:1];

  always_comb begin
    if (!sub_r) begin
      src = SRC_DIRECT;
    end else if (col_r[0]) begin
      src = SRC_HELD;
    end else if (fetch_row) begin
      src = SRC_FETCH;
    end else begin
      src = SRC_LINE;
    end
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_comb begin
    f_valid_nxt = f_valid_r;
    if (accept) begin
      f_valid_nxt = 1'b1;
    end else if (f_move) begin
      f_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      f_valid_r <= 1'b0;
    end else begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      f_valid_r <= f_valid_nxt;
    end
  end

  // staged payload
  always_ff @(posedge clk) begin
    if (accept) begin
      f_luma_r  <= in_luma;
      f_cu_r    <= in_chroma_u;
      f_cv_r    <= in_chroma_v;
      f_alpha_r <= alpha_pres_r ? in_alpha_in : ALPHA_OPAQUE;
      f_last_r  <= last_col && last_row;
      f_src_r   <= src;
    end
  end

  // line buffer: write on fetching rows, read on the rows that reuse it
  always_ff @(posedge clk) begin
    if (accept && (src == SRC_FETCH)) begin
      line_mem[idx] <= {in_chroma_v, in_chroma_u};
    end
    if (accept && (src == SRC_LINE)) begin
      rdata_r <= line_mem[idx];
    end
  end

  always_comb begin
    case (f_src_r)
      SRC_DIRECT: pair = {f_cv_r, f_cu_r};
      SRC_FETCH:  pair = {f_cv_r, f_cu_r};
      SRC_LINE:   pair = rdata_r;
      SRC_HELD:   pair = held_r;
      default:    pair = held_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (f_move && ((f_src_r == SRC_FETCH) || (f_src_r == SRC_LINE))) begin
      held_r <= pair;
    end
  end

  assign q_push      = f_move;
  assign q_item.luma  = f_luma_r;
  assign q_item.pair  = pair;
  assign q_item.alpha = f_alpha_r;
  assign q_item.last  = f_last_r;

`ifndef ASSERT_OFF
  // the frame's last pixel returns the raster to the origin
  a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last_col && last_row) |=> (col_r == '0 && row_r == '0))
    else $error("raster counters not cleared after frame end");

  // a staged request is never overwritten before it moves on
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (f_valid_r && q_full) |-> !accept)
    else $error("staged request overwritten");
`endif

endmodule

// File: rtl/core/yuvc_queue.sv
// ----------------------------------------------------------------------------
// yuvc_queue - short request queue between front and back
// register-based fifo of classified pixels
// ----------------------------------------------------------------------------
module yuvc_queue
  import yuvc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  q_push,
  input  item_t q_item,
  output logic  q_full,
  input  logic  q_pop,
  output item_t q_head,
  output logic  q_empty
);

  item_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;
  logic               do_push, do_pop;

  assign q_full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_empty = (count_r == '0);
  assign do_push = q_push && !q_full;
  assign do_pop  = q_pop && !q_empty;
  assign q_head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= q_item;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");
`endif

endmodule

// File: rtl/core/yuvc_back.sv
// ----------------------------------------------------------------------------
// yuvc_back - color math, clamping and frame sums
// three elastic stages: products, round and clamp, accumulate and output
// ----------------------------------------------------------------------------
module yuvc_back
  import yuvc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // queue head
  input  item_t            q_head,
  input  logic             q_empty,
  output logic             q_pop,
  // result channel
  output logic             empty,
  input  logic             pop,
  output logic [7:0]       out_blue,
  output logic [7:0]       out_green,
  output logic [7:0]       out_red,
  output logic [7:0]       out_alpha_out,
  output logic             out_frame_end,
  output logic [SUM_W-1:0] out_sum_blue,
  output logic [SUM_W-1:0] out_sum_green,
  output logic [SUM_W-1:0] out_sum_red,
  output logic [SUM_W-1:0] out_sum_alpha
);

  // stage 1: products
  logic                     s1_valid_r;
  logic signed [PROD_W-1:0] s1_ky_r, s1_bu_r, s1_gu_r, s1_gv_r, s1_rv_r;
  logic [7:0]               s1_alpha_r;
  logic                     s1_last_r;
  // stage 2: channels
  logic                     s2_valid_r;
  logic [7:0]               s2_b_r, s2_g_r, s2_r_r, s2_a_r;
  logic                     s2_last_r;
  // output stage
  logic                     o_valid_r;
  logic [SUM_W-1:0]         acc_b_r, acc_g_r, acc_r_r, acc_a_r;
  logic [SUM_W-1:0]         sum_b, sum_g, sum_r, sum_a;

  logic                     s1_ready, s2_ready, o_ready;
  logic                     s1_load, s2_load, o_load;
  logic signed [PROD_W-1:0] y_ext, p_ext, q_ext;

  assign o_ready  = !o_valid_r || pop;
  assign s2_ready = !s2_valid_r || o_ready;
  assign s1_ready = !s1_valid_r || s2_ready;

  assign s1_load = !q_empty && s1_ready;
  assign s2_load = s1_valid_r && s2_ready;
  assign o_load  = s2_valid_r && o_ready;
  assign q_pop   = s1_load;

  assign y_ext = PROD_W'($signed({1'b0, q_head.luma}) - $signed({1'b0, LUMA_OFFSET}));
  assign p_ext = PROD_W'($signed({1'b0, q_head.pair[7:0]}) - $signed({1'b0, CHROMA_OFFSET}));
  assign q_ext = PROD_W'($signed({1'b0, q_head.pair[15:8]}) - $signed({1'b0, CHROMA_OFFSET}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_r <= !q_empty;
      if (s2_ready) s2_valid_r <= s1_valid_r;
      if (o_ready)  o_valid_r  <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_ky_r    <= y_ext * K_LUMA;
      s1_bu_r    <= p_ext * K_BLUE_U;
      s1_gu_r    <= p_ext * K_GREEN_U;
      s1_gv_r    <= q_ext * K_GREEN_V;
      s1_rv_r    <= q_ext * K_RED_V;
      s1_alpha_r <= q_head.alpha;
      s1_last_r  <= q_head.last;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_b_r    <= to_channel(s1_ky_r + s1_bu_r);
      s2_g_r    <= to_channel(s1_ky_r - s1_gu_r - s1_gv_r);
      s2_r_r    <= to_channel(s1_ky_r + s1_rv_r);
      s2_a_r    <= s1_alpha_r;
      s2_last_r <= s1_last_r;
    end
  end

  assign sum_b = acc_b_r + SUM_W'(s2_b_r);
  assign sum_g = acc_g_r + SUM_W'(s2_g_r);
  assign sum_r = acc_r_r + SUM_W'(s2_r_r);
  assign sum_a = acc_a_r + SUM_W'(s2_a_r);

  // running sums clear after the frame's last pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_b_r <= '0;
      acc_g_r <= '0;
      acc_r_r <= '0;
      acc_a_r <= '0;
    end else if (o_load) begin
      acc_b_r <= s2_last_r ? '0 : sum_b;
      acc_g_r <= s2_last_r ? '0 : sum_g;
      acc_r_r <= s2_last_r ? '0 : sum_r;
      acc_a_r <= s2_last_r ? '0 : sum_a;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      out_blue      <= s2_b_r;
      out_green     <= s2_g_r;
      out_red       <= s2_r_r;
      out_alpha_out <= s2_a_r;
      out_frame_end <= s2_last_r;
      out_sum_blue  <= sum_b;
      out_sum_green <= sum_g;
      out_sum_red   <= sum_r;
      out_sum_alpha <= sum_a;
    end
  end

  assign empty = !o_valid_r;

`ifndef ASSERT_OFF
  a_sums_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (o_load && s2_last_r) |=>
      (acc_b_r == '0 && acc_g_r == '0 && acc_r_r == '0 && acc_a_r == '0))
    else $error("frame sums not cleared after frame end");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !o_ready) |=> s2_valid_r)
    else $error("stage 2 request dropped during stall");
`endif

endmodule

// File: rtl/core/yuv_to_bgra_pixel_converter_top.sv
// ----------------------------------------------------------------------------
// yuv_to_bgra_pixel_converter_top - streaming yuv to bgra pixel converter
// one pixel per request in raster order, bt.601 style 16.16 fixed point,
// optional 2x2 chroma subsampling through a line buffer, frame sums
// ----------------------------------------------------------------------------
//
//  channel   handshake          payload
//  -------   ----------------   ---------------------------------------------
//  input     push / full        in_luma, in_chroma_u, in_chroma_v, in_alpha_in
//  result    pop / empty        out_blue/green/red/alpha_out, out_frame_end,
//                               out_sum_blue/green/red/alpha
//  config    cfg_valid / ready  cfg_index, cfg_data (always ready)
//
//  one pixel per clock sustained while results are popped; a request is held
//  in the front stage, then in the queue, products, clamp and output registers
//  the front stage, a four-entry queue and the back pipeline each stall on
//  their own; full only rises when the front stage and queue are both held
//  synchronous active-low reset clears counters, held chroma, sums and valids
//  the chroma line buffer needs no clearing pass: a row reads only what an
//  earlier row of the same frame wrote
//
module yuv_to_bgra_pixel_converter_top
  import yuvc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // config
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // input requests
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           in_luma,
  input  logic [7:0]           in_chroma_u,
  input  logic [7:0]           in_chroma_v,
  input  logic [7:0]           in_alpha_in,
  // results
  output logic                 empty,
  input  logic                 pop,
  output logic [7:0]           out_blue,
  output logic [7:0]           out_green,
  output logic [7:0]           out_red,
  output logic [7:0]           out_alpha_out,
  output logic                 out_frame_end,
  output logic [SUM_W-1:0]     out_sum_blue,
  output logic [SUM_W-1:0]     out_sum_green,
  output logic [SUM_W-1:0]     out_sum_red,
  output logic [SUM_W-1:0]     out_sum_alpha
);

  // front to queue
  logic  fq_push, fq_full;
  item_t fq_item;
  // queue to back
  logic  qb_pop, qb_empty;
  item_t qb_head;

  // config writes are taken every cycle
  assign cfg_ready = 1'b1;

  // intake, raster tracking and chroma selection
  yuvc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push        (push),
    .full        (full),
    .in_luma     (in_luma),
    .in_chroma_u (in_chroma_u),
    .in_chroma_v (in_chroma_v),
    .in_alpha_in (in_alpha_in),
    .q_push      (fq_push),
    .q_item      (fq_item),
    .q_full      (fq_full)
  );

  // decoupling queue
  yuvc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (fq_push),
    .q_item  (fq_item),
    .q_full  (fq_full),
    .q_pop   (qb_pop),
    .q_head  (qb_head),
    .q_empty (qb_empty)
  );

  // color math and frame sums
  yuvc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_head        (qb_head),
    .q_empty       (qb_empty),
    .q_pop         (qb_pop),
    .empty         (empty),
    .pop           (pop),
    .out_blue      (out_blue),
    .out_green     (out_green),
    .out_red       (out_red),
    .out_alpha_out (out_alpha_out),
    .out_frame_end (out_frame_end),
    .out_sum_blue  (out_sum_blue),
    .out_sum_green (out_sum_green),
    .out_sum_red   (out_sum_red),
    .out_sum_alpha (out_sum_alpha)
  );

endmodule

// File: tb/yuv_to_bgra_pixel_converter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv_to_bgra_pixel_converter_checker - pixel predictor and result scoreboard
// watches the config, request and result channels, predicts every pixel from
// its own copy of the converter state and compares results field by field
// ----------------------------------------------------------------------------
module yuv_to_bgra_pixel_converter_checker
  import yuvc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 push,
  input  logic                 full,
  input  logic [7:0]           in_luma,
  input  logic [7:0]           in_chroma_u,
  input  logic [7:0]           in_chroma_v,
  input  logic [7:0]           in_alpha_in,
  input  logic                 empty,
  input  logic                 pop,
  input  logic [7:0]           out_blue,
  input  logic [7:0]           out_green,
  input  logic [7:0]           out_red,
  input  logic [7:0]           out_alpha_out,
  input  logic                 out_frame_end,
  input  logic [SUM_W-1:0]     out_sum_blue,
  input  logic [SUM_W-1:0]     out_sum_green,
  input  logic [SUM_W-1:0]     out_sum_red,
  input  logic [SUM_W-1:0]     out_sum_alpha,
  input  logic                 drain_done,
  output int                   fail_count,
  output int                   pending
);

  // 16.16 coefficients
  localparam int COEF_Y  = 76283;
  localparam int COEF_RV = 132251;
  localparam int COEF_GU = 53281;
  localparam int COEF_GV = 25624;
  localparam int COEF_BU = 104595;

  typedef struct packed {
    logic [7:0]       blue;
    logic [7:0]       green;
    logic [7:0]       red;
    logic [7:0]       alpha;
    logic             frame_end;
    logic [SUM_W-1:0] sum_blue;
    logic [SUM_W-1:0] sum_green;
    logic [SUM_W-1:0] sum_red;
    logic [SUM_W-1:0] sum_alpha;
  } bgra_pixel_t;

  logic [CFG_W-1:0] width_cfg;
  logic [CFG_W-1:0] height_cfg;
  logic             subsample_cfg;
  logic             alpha_cfg;
  int unsigned      col_pos;
  int unsigned      row_pos;
  logic [15:0]      held_pair;
  logic [15:0]      chroma_row [LINE_DEPTH];
  logic [SUM_W-1:0] frame_sum [4];
  bgra_pixel_t      expected_pixels [$];
  int unsigned      result_num;
  bit               leftover_checked;

  task automatic report_fail(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_fail($sformatf("result %0d %s: got %0d, expected %0d",
                            result_num, name, got, want));
    end
  endtask

  // 0 counts as 1, anything above the limit is the limit
  function automatic int unsigned clip_dim(input logic [CFG_W-1:0] v,
                                           input int unsigned lim);
    if (v == '0) begin
      return 1;
    end
    return (v > lim) ? lim : v;
  endfunction

  // round at bit 15, drop 16 fraction bits, clamp to a byte
  function automatic logic [7:0] clamp_channel(input int acc);
    int t;
    t = acc + 32768;
    if (t < 0) begin
      return 8'd0;
    end
    t = t >>> 16;
    return (t > 255) ? 8'hff : t[7:0];
  endfunction

  // one pixel: pick its chroma pair, convert, accumulate, advance raster
  function automatic bgra_pixel_t convert_pixel(input logic [7:0] luma,
                                                input logic [7:0] u,
                                                input logic [7:0] v,
                                                input logic [7:0] a);
    int unsigned w;
    int unsigned h;
    int unsigned col;
    int unsigned row;
    logic [15:0] pair;
    int lv;
    int pv;
    int qv;
    int y;
    int p;
    int q;
    bgra_pixel_t px;
    w   = clip_dim(width_cfg, MAX_WIDTH);
    h   = clip_dim(height_cfg, MAX_HEIGHT);
    col = col_pos;
    row = row_pos;
    if (subsample_cfg) begin
      if (col[0] == 1'b0) begin
        if (row[0] == 1'b0 && (row == 0 || (row >> 1) < (h >> 1))) begin
          held_pair = {v, u};
          chroma_row[col >> 1] = held_pair;
        end else begin
          held_pair = chroma_row[col >> 1];
        end
      end
      pair = held_pair;
    end else begin
      pair = {v, u};
    end
    lv = luma;
    pv = pair[7:0];
    qv = pair[15:8];
    y  = lv - 16;
    p  = pv - 128;
    q  = qv - 128;
    px.blue  = clamp_channel(COEF_Y * y + COEF_BU * p);
    px.green = clamp_channel(COEF_Y * y - COEF_GU * p - COEF_GV * q);
    px.red   = clamp_channel(COEF_Y * y + COEF_RV * q);
    px.alpha = alpha_cfg ? a : 8'hff;
    frame_sum[0] += px.blue;
    frame_sum[1] += px.green;
    frame_sum[2] += px.red;
    frame_sum[3] += px.alpha;
    px.frame_end = (col + 1 >= w) && (row + 1 >= h);
    px.sum_blue  = frame_sum[0];
    px.sum_green = frame_sum[1];
    px.sum_red   = frame_sum[2];
    px.sum_alpha = frame_sum[3];
    if (col + 1 >= w) begin
      col_pos = 0;
      row_pos = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col_pos = col + 1;
    end
    if (px.frame_end) begin
      frame_sum = '{default: '0};
    end
    return px;
  endfunction

  always @(posedge clk) begin : watch
    bgra_pixel_t want;
    if (!rst_n) begin
      width_cfg     = CFG_W'(16);
      height_cfg    = CFG_W'(16);
      subsample_cfg = 1'b0;
      alpha_cfg     = 1'b0;
      col_pos       = 0;
      row_pos       = 0;
      held_pair     = '0;
      frame_sum     = '{default: '0};
      expected_pixels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_FRAME_WIDTH:  width_cfg     = cfg_data;
          CFG_FRAME_HEIGHT: height_cfg    = cfg_data;
          CFG_CHROMA_SUB:   subsample_cfg = cfg_data[0];
          CFG_ALPHA_PRES:   alpha_cfg     = cfg_data[0];
          default: ;
        endcase
      end
      if (push && !full) begin
        expected_pixels.insert(expected_pixels.size(),
                               convert_pixel(in_luma, in_chroma_u, in_chroma_v,
                                             in_alpha_in));
      end
      if (pop && !empty) begin
        result_num++;
        if (expected_pixels.size() == 0) begin
          report_fail($sformatf("result %0d arrived with nothing expected", result_num));
        end else begin
          want = expected_pixels.pop_front();
          check_field("blue", out_blue, want.blue);
          check_field("green", out_green, want.green);
          check_field("red", out_red, want.red);
          check_field("alpha_out", out_alpha_out, want.alpha);
          check_field("frame_end", out_frame_end, want.frame_end);
          check_field("sum_blue", out_sum_blue, want.sum_blue);
          check_field("sum_green", out_sum_green, want.sum_green);
          check_field("sum_red", out_sum_red, want.sum_red);
          check_field("sum_alpha", out_sum_alpha, want.sum_alpha);
        end
      end
      if (drain_done && !leftover_checked) begin
        leftover_checked = 1'b1;
        if (expected_pixels.size() != 0) begin
          report_fail($sformatf("%0d expected pixels never came out",
                                expected_pixels.size()));
        end
      end
    end
    pending <= expected_pixels.size();
  end

endmodule

// File: tb/tb_yuv_to_bgra_pixel_converter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_yuv_to_bgra_pixel_converter_top - testbench of the yuv to bgra converter
// drives frame formats and pixel requests with random gaps on both channels,
// a separate checker predicts and compares every pixel, this top gives the
// verdict
// ----------------------------------------------------------------------------
module tb_yuv_to_bgra_pixel_converter_top;
  import yuvc_pkg::*;

  // cycles with no handshake anywhere before the run is declared hung
  localparam int STALL_LIMIT = 2000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 push = 1'b0;
  logic                 full;
  logic [7:0]           in_luma = '0;
  logic [7:0]           in_chroma_u = '0;
  logic [7:0]           in_chroma_v = '0;
  logic [7:0]           in_alpha_in = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [7:0]           out_blue;
  logic [7:0]           out_green;
  logic [7:0]           out_red;
  logic [7:0]           out_alpha_out;
  logic                 out_frame_end;
  logic [SUM_W-1:0]     out_sum_blue;
  logic [SUM_W-1:0]     out_sum_green;
  logic [SUM_W-1:0]     out_sum_red;
  logic [SUM_W-1:0]     out_sum_alpha;

  logic        drain_done = 1'b0;
  int          fail_count;
  int          pending;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          stall_cycles = 0;
  int unsigned sent_total = 0;

  always #1 clk = ~clk;

  yuv_to_bgra_pixel_converter_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .push          (push),
    .full          (full),
    .in_luma       (in_luma),
    .in_chroma_u   (in_chroma_u),
    .in_chroma_v   (in_chroma_v),
    .in_alpha_in   (in_alpha_in),
    .empty         (empty),
    .pop           (pop),
    .out_blue      (out_blue),
    .out_green     (out_green),
    .out_red       (out_red),
    .out_alpha_out (out_alpha_out),
    .out_frame_end (out_frame_end),
    .out_sum_blue  (out_sum_blue),
    .out_sum_green (out_sum_green),
    .out_sum_red   (out_sum_red),
    .out_sum_alpha (out_sum_alpha)
  );

  yuv_to_bgra_pixel_converter_checker pixel_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .push          (push),
    .full          (full),
    .in_luma       (in_luma),
    .in_chroma_u   (in_chroma_u),
    .in_chroma_v   (in_chroma_v),
    .in_alpha_in   (in_alpha_in),
    .empty         (empty),
    .pop           (pop),
    .out_blue      (out_blue),
    .out_green     (out_green),
    .out_red       (out_red),
    .out_alpha_out (out_alpha_out),
    .out_frame_end (out_frame_end),
    .out_sum_blue  (out_sum_blue),
    .out_sum_green (out_sum_green),
    .out_sum_red   (out_sum_red),
    .out_sum_alpha (out_sum_alpha),
    .drain_done    (drain_done),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  // result side: pop is redrawn every cycle, stalls at the current rate
  always @(posedge clk) begin
    pop <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog: any accepted request, result or register write restarts it
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // one register write; valid stays up so back-to-back writes need no gap
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // full frame format, all four registers
  task automatic set_format(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                            input logic sub, input logic alpha);
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    write_reg(CFG_CHROMA_SUB, CFG_W'(sub));
    write_reg(CFG_ALPHA_PRES, CFG_W'(alpha));
    cfg_valid <= 1'b0;
  endtask

  // one pixel request, optionally preceded by idle cycles; push stays high
  // afterwards so consecutive requests can go out on consecutive clocks
  task automatic send_pixel(input logic [7:0] l, input logic [7:0] u,
                            input logic [7:0] v, input logic [7:0] a);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push        <= 1'b1;
    in_luma     <= l;
    in_chroma_u <= u;
    in_chroma_v <= v;
    in_alpha_in <= a;
    @(posedge clk);
    while (full) @(posedge clk);
    sent_total++;
  endtask

  // stop requesting and wait until every predicted pixel has been popped
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // extremes show up more often than a flat draw would give them
  function automatic logic [7:0] rand_sample();
    case ($urandom_range(7))
      0:       return 8'd0;
      1:       return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_random(input int unsigned n);
    repeat (n) send_pixel(rand_sample(), rand_sample(), rand_sample(), rand_sample());
  endtask

  // random formats, each held for one to three whole frames so that every
  // format change lands on a frame boundary
  task automatic run_random(input int unsigned quota);
    int unsigned w;
    int unsigned h;
    int unsigned target;
    target = sent_total + quota;
    while (sent_total < target) begin
      case ($urandom_range(9))
        0, 1:    w = $urandom_range(11, 48);
        2:       w = $urandom_range(1, 2);
        default: w = $urandom_range(3, 10);
      endcase
      h = ($urandom_range(4) == 0) ? $urandom_range(6, 9) : $urandom_range(1, 5);
      drain();
      set_format(w, h, 1'($urandom_range(1)), 1'($urandom_range(1)));
      send_random(w * h * $urandom_range(1, 3));
    end
  endtask

  initial begin : stimulus
    int i;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // first pass: sender idles lightly, receiver stalls often
    send_idle_pct = 22;
    recv_idle_pct = 54;

    // full chroma, alpha through: black, white, below black, saturation,
    // extreme chroma corners; a 4x2 frame so the last one flags frame end
    set_format(4, 2, 1'b0, 1'b1);
    send_pixel(8'd16, 8'd128, 8'd128, 8'd0);
    send_pixel(8'd255, 8'd128, 8'd128, 8'd255);
    send_pixel(8'd0, 8'd0, 8'd0, 8'd85);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd170);
    send_pixel(8'd0, 8'd255, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd0, 8'd255, 8'd254);
    send_pixel(8'd128, 8'd0, 8'd255, 8'd128);
    send_pixel(8'd235, 8'd240, 8'd16, 8'd127);

    // subsampled 3x3, alpha forced opaque: odd columns reuse the held pair,
    // row one reads the line buffer, row two repeats the last chroma row
    drain();
    set_format(3, 3, 1'b1, 1'b0);
    for (i = 0; i < 9; i++) begin
      send_pixel(8'(30 * i), 8'(20 * i + 10), 8'(250 - 25 * i), 8'(28 * i));
    end

    // zero width and height act as a one-pixel frame
    drain();
    set_format(0, 0, 1'b0, 1'b1);
    send_pixel(8'd100, 8'd60, 8'd200, 8'd33);
    send_pixel(8'd17, 8'd129, 8'd127, 8'd222);

    // widest frame via a clipped width, cut short by shrinking the width
    // below the current column between requests
    drain();
    set_format(8191, 1, 1'b1, 1'b1);
    send_random(40);
    drain();
    write_reg(CFG_FRAME_WIDTH, 20);
    cfg_valid <= 1'b0;
    send_random(1);

    // exact maximum width with zero height, ended by a shrink past it
    drain();
    set_format(4096, 0, 1'b1, 1'b0);
    send_random(36);
    drain();
    write_reg(CFG_FRAME_WIDTH, 38);
    cfg_valid <= 1'b0;
    send_random(2);

    // one column, tallest frame, ended by dropping the height to zero
    drain();
    set_format(1, 8191, 1'b1, 1'b1);
    send_random(30);
    drain();
    write_reg(CFG_FRAME_HEIGHT, 0);
    cfg_valid <= 1'b0;
    send_random(1);

    run_random(400);

    // second pass: sender idles often, receiver lightly
    send_idle_pct = 54;
    recv_idle_pct = 22;
    run_random(420);

    // third pass: full rate both ways
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(420);

    // let the pipeline settle, then ask the checker for leftovers
    drain();
    repeat (10) @(posedge clk);
    drain_done <= 1'b1;
    repeat (2) @(posedge clk);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: yuv_to_bgra_pixel_converter_top.f
rtl/core/yuvc_pkg.sv
rtl/core/yuvc_front.sv
rtl/core/yuvc_queue.sv
rtl/core/yuvc_back.sv
rtl/core/yuv_to_bgra_pixel_converter_top.sv
tb/yuv_to_bgra_pixel_converter_checker.sv
tb/tb_yuv_to_bgra_pixel_converter_top.sv
